FILE: hw/rtl/mcr_pkg.sv
package mcr_pkg;

    localparam int COORD_BITS = 16;
    localparam int PT_BITS    = COORD_BITS + 1;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int CFG_BITS   = 16;
    localparam int COLOUR_BITS = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int PTS_PER_STEP = 8;
    localparam int CNT_BITS   = $clog2(PTS_PER_STEP);

    localparam logic [CNT_BITS-1:0] LAST_PT = CNT_BITS'(PTS_PER_STEP - 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(480);

    localparam logic [DEC_BITS-1:0] DEC_INIT    = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] DEC_INC_NEG = DEC_BITS'(6);
    localparam logic [DEC_BITS-1:0] DEC_INC_POS = DEC_BITS'(10);

    typedef struct packed {
        logic signed [PT_BITS-1:0]    x;
        logic signed [PT_BITS-1:0]    y;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [COLOUR_BITS-1:0]       colour;
        logic                         done;
    } job_t;

endpackage

FILE: hw/rtl/mcr_core.sv
module mcr_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 opcode,
    input  logic signed [mcr_pkg::COORD_BITS-1:0] centre_x,
    input  logic signed [mcr_pkg::COORD_BITS-1:0] centre_y,
    input  logic [mcr_pkg::RAD_BITS-1:0]          radius,
    input  logic [mcr_pkg::COLOUR_BITS-1:0]       colour,
    output logic                                 push,
    output mcr_pkg::job_t                        job
);
    import mcr_pkg::*;

    logic                         active_reg, active_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [PT_BITS-1:0]    x_reg, x_next;
    logic signed [PT_BITS-1:0]    y_reg, y_next;
    logic signed [DEC_BITS-1:0]   dec_reg, dec_next;
    logic [COLOUR_BITS-1:0]       colour_reg, colour_next;

    logic signed [PT_BITS-1:0]    x_inc;
    logic signed [PT_BITS-1:0]    y_dec;
    logic [PT_BITS:0]             diff;
    logic [DEC_BITS-1:0]          dec_neg;
    logic [DEC_BITS-1:0]          dec_pos;
    logic [DEC_BITS-1:0]          dec_start;

    // term updates, all wrapping at register width
    assign x_inc     = x_reg + PT_BITS'(1);
    assign y_dec     = y_reg - PT_BITS'(1);
    assign diff      = {x_reg[PT_BITS-1], x_reg} - {y_reg[PT_BITS-1], y_reg};
    assign dec_neg   = dec_reg + DEC_BITS'({x_reg, 2'b00}) + DEC_INC_NEG;
    assign dec_pos   = dec_reg + DEC_BITS'({diff, 2'b00}) + DEC_INC_POS;
    assign dec_start = DEC_INIT - DEC_BITS'({radius, 1'b0});

    assign push = accept && (opcode == OP_STEP) && active_reg;

    always_comb
    begin
        active_next = active_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        dec_next    = dec_reg;
        colour_next = colour_reg;
        if (accept && (opcode == OP_START))
        begin
            active_next = 1'b1;
            cx_next     = centre_x;
            cy_next     = centre_y;
            x_next      = '0;
            y_next      = PT_BITS'(radius);
            dec_next    = dec_start;
            colour_next = colour;
        end
        else if (push)
        begin
            if (dec_reg[DEC_BITS-1])
            begin
                dec_next = dec_neg;
            end
            else
            begin
                dec_next = dec_pos;
                y_next   = y_dec;
            end
            x_next = x_inc;
            if (x_inc > y_next)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        job.x      = x_reg;
        job.y      = y_reg;
        job.cx     = cx_reg;
        job.cy     = cy_reg;
        job.colour = colour_reg;
        job.done   = (x_next > y_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            dec_reg    <= '0;
            colour_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            dec_reg    <= dec_next;
            colour_reg <= colour_next;
        end
    end

endmodule

FILE: hw/rtl/mcr_emit.sv
module mcr_emit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [mcr_pkg::CFG_BITS-1:0]           cfg_data,
    input  logic                                   push,
    input  mcr_pkg::job_t                          job,
    output logic                                   job_ready,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [mcr_pkg::PT_BITS-1:0]     point_x,
    output logic signed [mcr_pkg::PT_BITS-1:0]     point_y,
    output logic [mcr_pkg::COLOUR_BITS-1:0]        point_colour,
    output logic                                   visible,
    output logic                                   last_of_step,
    output logic                                   circle_done
);
    import mcr_pkg::*;

    logic [CFG_BITS-1:0]       fw_reg, fw_next;
    logic [CFG_BITS-1:0]       fh_reg, fh_next;
    job_t                      job_reg, job_next;
    logic                      job_valid_reg, job_valid_next;
    logic [CNT_BITS-1:0]       cnt_reg, cnt_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [PT_BITS-1:0] px_reg, px_next;
    logic signed [PT_BITS-1:0] py_reg, py_next;
    logic [COLOUR_BITS-1:0]    colour_reg, colour_next;
    logic                      vis_reg, vis_next;
    logic                      last_reg, last_next;
    logic                      done_reg, done_next;

    logic                      out_load;
    logic                      job_end;
    logic signed [PT_BITS-1:0] col_off;
    logic signed [PT_BITS-1:0] row_off;
    logic signed [PT_BITS:0]   col;
    logic signed [PT_BITS:0]   row;
    logic                      col_in;
    logic                      row_in;

    assign out_load  = job_valid_reg && (!out_valid_reg || !out_stall);
    assign job_end   = out_load && (cnt_reg == LAST_PT);
    assign job_ready = !job_valid_reg || job_end;

    // octant select: bit 2 swaps axes, bit 0 mirrors column, bit 1 mirrors row
    always_comb
    begin
        col_off = cnt_reg[2] ? job_reg.y : job_reg.x;
        row_off = cnt_reg[2] ? job_reg.x : job_reg.y;
        col = {{2{job_reg.cx[COORD_BITS-1]}}, job_reg.cx};
        row = {{2{job_reg.cy[COORD_BITS-1]}}, job_reg.cy};
        if (cnt_reg[0])
        begin
            col = col - {col_off[PT_BITS-1], col_off};
        end
        else
        begin
            col = col + {col_off[PT_BITS-1], col_off};
        end
        if (cnt_reg[1])
        begin
            row = row - {row_off[PT_BITS-1], row_off};
        end
        else
        begin
            row = row + {row_off[PT_BITS-1], row_off};
        end
        col_in = !col[PT_BITS] && (col[PT_BITS-1:0] < {1'b0, fw_reg});
        row_in = !row[PT_BITS] && (row[PT_BITS-1:0] < {1'b0, fh_reg});
    end

    always_comb
    begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_next = cfg_data;
                REG_FRAME_HEIGHT: fh_next = cfg_data;
                default:          fw_next = fw_reg;
            endcase
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        cnt_next       = cnt_reg;
        if (push)
        begin
            job_next       = job;
            job_valid_next = 1'b1;
        end
        else if (job_end)
        begin
            job_valid_next = 1'b0;
        end
        if (out_load)
        begin
            cnt_next = job_end ? '0 : cnt_reg + CNT_BITS'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        colour_next    = colour_reg;
        vis_next       = vis_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            px_next        = col[PT_BITS-1:0];
            py_next        = row[PT_BITS-1:0];
            colour_next    = job_reg.colour;
            vis_next       = col_in && row_in;
            last_next      = job_end;
            done_next      = job_end && job_reg.done;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= FRAME_WIDTH_RST;
            fh_reg        <= FRAME_HEIGHT_RST;
            job_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            job_valid_reg <= job_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        colour_reg <= colour_next;
        vis_reg    <= vis_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign point_colour = colour_reg;
    assign visible      = vis_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

FILE: hw/rtl/midpoint_circle_rasterizer_top.sv
// midpoint circle outline generator
// input channel (in_valid / in_stall): opcode 0 loads centre, radius and colour
// and starts a circle; opcode 1 advances the active circle by one step
// output channel (out_valid / out_stall): each step gives eight points in
// octant order, one transfer per cycle while out_stall is low, last_of_step
// on the eighth and circle_done on the eighth point of the final step
// a start, or a step while no circle is active, gives no points
// a step is registered in the job register and its first point then in the
// output register; the others follow one per cycle while out_stall is low
// the single output register sends one point per cycle unless stalled; the next
// item is taken in the cycle the eighth point is loaded, so steps run back to
// back with no gap
// frame_width / frame_height are written through cfg_we, cfg_index, cfg_data
// and only matter for the visible flag
// reset clears the circle state, drops pending points and sets the frame to
// 640 by 480
// while out_stall is high the current point holds; in_stall is high while a
// step still has points to load, so an output stall soon holds the input too
module midpoint_circle_rasterizer_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [mcr_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic signed [mcr_pkg::COORD_BITS-1:0] centre_x,
    input  logic signed [mcr_pkg::COORD_BITS-1:0] centre_y,
    input  logic [mcr_pkg::RAD_BITS-1:0]          radius,
    input  logic [mcr_pkg::COLOUR_BITS-1:0]       colour,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mcr_pkg::PT_BITS-1:0]    point_x,
    output logic signed [mcr_pkg::PT_BITS-1:0]    point_y,
    output logic [mcr_pkg::COLOUR_BITS-1:0]       point_colour,
    output logic                                  visible,
    output logic                                  last_of_step,
    output logic                                  circle_done
);
    import mcr_pkg::*;

    logic accept;
    logic push;
    logic job_ready;
    job_t job;

    assign in_stall = !job_ready;
    assign accept   = in_valid && job_ready;

    mcr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (opcode),
        .centre_x (centre_x),
        .centre_y (centre_y),
        .radius   (radius),
        .colour   (colour),
        .push     (push),
        .job      (job)
    );

    mcr_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .job          (job),
        .job_ready    (job_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_colour (point_colour),
        .visible      (visible),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 44;

    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [RAD_BITS-1:0]          r;
        logic [COLOUR_BITS-1:0]       colour;
    } circle_cmd_t;

    typedef struct packed {
        logic signed [PT_BITS-1:0] x;
        logic signed [PT_BITS-1:0] y;
        logic [COLOUR_BITS-1:0]    colour;
        logic                      vis;
        logic                      last;
        logic                      done;
    } point_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          opcode = OP_START;
    logic signed [COORD_BITS-1:0]  centre_x = '0;
    logic signed [COORD_BITS-1:0]  centre_y = '0;
    logic [RAD_BITS-1:0]           radius = '0;
    logic [COLOUR_BITS-1:0]        colour = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [PT_BITS-1:0]     point_x;
    logic signed [PT_BITS-1:0]     point_y;
    logic [COLOUR_BITS-1:0]        point_colour;
    logic                          visible;
    logic                          last_of_step;
    logic                          circle_done;

    // circle tracker state
    logic                          circ_active = 1'b0;
    logic signed [COORD_BITS-1:0]  ctr_col = '0;
    logic signed [COORD_BITS-1:0]  ctr_row = '0;
    logic signed [PT_BITS-1:0]     off_x = '0;
    logic signed [PT_BITS-1:0]     off_y = '0;
    logic signed [DEC_BITS-1:0]    decision = '0;
    logic [COLOUR_BITS-1:0]        pen = '0;
    logic [CFG_BITS-1:0]           frame_w = FRAME_WIDTH_RST;
    logic [CFG_BITS-1:0]           frame_h = FRAME_HEIGHT_RST;

    circle_cmd_t pending_cmds[$];
    point_t      expected_points[$];

    logic in_fire = 1'b0;
    logic idle_on = 1'b1;
    int   in_gap = 0;
    int   stall_left = 0;
    int   errors = 0;
    int   quiet_cycles = 0;

    midpoint_circle_rasterizer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .centre_x     (centre_x),
        .centre_y     (centre_y),
        .radius       (radius),
        .colour       (colour),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_colour (point_colour),
        .visible      (visible),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

    always #5 clk = ~clk;

    function automatic point_t plot(input int px, input int py, input logic last,
                                    input logic done);
        point_t p;
        p.x      = PT_BITS'(px);
        p.y      = PT_BITS'(py);
        p.colour = pen;
        p.vis    = (px >= 0) && (py >= 0) && (px < int'(frame_w)) && (py < int'(frame_h));
        p.last   = last;
        p.done   = done;
        return p;
    endfunction

    task automatic trace_circle(input circle_cmd_t c);
        int   x;
        int   y;
        int   cxi;
        int   cyi;
        int   ri;
        int   nd;
        logic fin;
        if (c.op == OP_START)
        begin
            ri          = c.r;
            ctr_col     = c.cx;
            ctr_row     = c.cy;
            pen         = c.colour;
            off_x       = '0;
            off_y       = PT_BITS'(ri);
            decision    = DEC_BITS'(3 - 2 * ri);
            circ_active = 1'b1;
        end
        else if (circ_active)
        begin
            x   = off_x;
            y   = off_y;
            cxi = ctr_col;
            cyi = ctr_row;
            if (decision < 0)
                nd = decision + 4 * x + 6;
            else
            begin
                nd    = decision + 4 * (x - y) + 10;
                off_y = PT_BITS'(y - 1);
            end
            decision = DEC_BITS'(nd);
            off_x    = PT_BITS'(x + 1);
            fin      = off_x > off_y;
            if (fin)
                circ_active = 1'b0;
            expected_points.push_back(plot(cxi + x, cyi + y, 1'b0, 1'b0));
            expected_points.push_back(plot(cxi - x, cyi + y, 1'b0, 1'b0));
            expected_points.push_back(plot(cxi + x, cyi - y, 1'b0, 1'b0));
            expected_points.push_back(plot(cxi - x, cyi - y, 1'b0, 1'b0));
            expected_points.push_back(plot(cxi + y, cyi + x, 1'b0, 1'b0));
            expected_points.push_back(plot(cxi - y, cyi + x, 1'b0, 1'b0));
            expected_points.push_back(plot(cxi + y, cyi - x, 1'b0, 1'b0));
            expected_points.push_back(plot(cxi - y, cyi - x, 1'b1, fin));
        end
    endtask

    task automatic push_start(input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy,
                              input logic [RAD_BITS-1:0] r,
                              input logic [COLOUR_BITS-1:0] col);
        circle_cmd_t c;
        c.op     = OP_START;
        c.cx     = cx;
        c.cy     = cy;
        c.r      = r;
        c.colour = col;
        pending_cmds.push_back(c);
    endtask

    task automatic push_steps(input int n);
        circle_cmd_t c;
        repeat (n)
        begin
            c.op     = OP_STEP;
            c.cx     = COORD_BITS'($urandom);
            c.cy     = COORD_BITS'($urandom);
            c.r      = RAD_BITS'($urandom);
            c.colour = $urandom;
            pending_cmds.push_back(c);
        end
    endtask

    // mostly whole or truncated circles near the frame, some anywhere, a few huge, some stray steps or starts
    task automatic queue_random_circle(output int useful);
        int sel;
        int r;
        int n;
        int span;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            push_steps(0);
            if ($urandom_range(0, 1) == 0)
                push_steps(1);
            else
                push_start(COORD_BITS'($urandom), COORD_BITS'($urandom),
                           RAD_BITS'($urandom), $urandom);
            useful = 1;
        end
        else
        begin
            if (sel < 70)
                r = $urandom_range(0, 24);
            else if (sel < 92)
                r = $urandom_range(25, 400);
            else
                r = $urandom_range(0, 32767);
            span = r * 3 / 4 + 2;
            if (r > 24)
                n = $urandom_range(1, 12);
            else if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, span);
            else
                n = span;
            if ($urandom_range(0, 3) == 0)
            begin
                cx = COORD_BITS'($urandom);
                cy = COORD_BITS'($urandom);
            end
            else
            begin
                cx = COORD_BITS'(int'($urandom_range(0, int'(frame_w) + 60)) - 30);
                cy = COORD_BITS'(int'($urandom_range(0, int'(frame_h) + 60)) - 30);
            end
            push_start(cx, cy, RAD_BITS'(r), $urandom);
            push_steps(n);
            useful = 1 + ((n < r * 707 / 1000 + 1) ? n : r * 707 / 1000 + 1);
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frame(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            frame_w = val;
        else
            frame_h = val;
    endtask

    // input driver
    always @(negedge clk)
    begin : feed_blk
        circle_cmd_t c;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_cmds.size() == 0)
                in_valid <= 1'b0;
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= $urandom_range(0, 12);
            end
            else
            begin
                c = pending_cmds.pop_front();
                opcode   <= c.op;
                centre_x <= c.cx;
                centre_y <= c.cy;
                radius   <= c.r;
                colour   <= c.colour;
                in_valid <= 1'b1;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin : watch_blk
        circle_cmd_t c;
        point_t      got;
        point_t      want;
        logic        moved;
        moved   = 1'b0;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                c.op     = opcode;
                c.cx     = centre_x;
                c.cy     = centre_y;
                c.r      = radius;
                c.colour = colour;
                trace_circle(c);
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved      = 1'b1;
                got.x      = point_x;
                got.y      = point_y;
                got.colour = point_colour;
                got.vis    = visible;
                got.last   = last_of_step;
                got.done   = circle_done;
                if (expected_points.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected point x=%0d y=%0d colour=%h %s=%b %s=%b %s=%b",
                                 got.x, got.y, got.colour, "vis", got.vis,
                                 "last", got.last, "done", got.done);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.colour !== want.colour
                        || got.vis !== want.vis || got.last !== want.last
                        || got.done !== want.done)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("point mismatch: expected x=%0d y=%0d colour=%h",
                                     want.x, want.y, want.colour);
                            $display("    expected vis=%b last=%b done=%b",
                                     want.vis, want.last, want.done);
                            $display("    got      x=%0d y=%0d colour=%h",
                                     got.x, got.y, got.colour);
                            $display("    got      vis=%b last=%b done=%b",
                                     got.vis, got.last, got.done);
                        end
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : main_blk
        int made;
        int u;
        int p;
        logic [CFG_BITS-1:0] widths[6];
        logic [CFG_BITS-1:0] heights[6];
        widths  = '{16'd0, 16'd1, 16'hFFFF, CFG_BITS'($urandom_range(1, 65535)),
                    16'd320, 16'd640};
        heights = '{16'd0, 16'd1, 16'hFFFF, CFG_BITS'($urandom_range(1, 65535)),
                    16'd200, 16'd480};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // step with no circle, zero radius, a small full circle, extreme centres and
        // radius, a start that replaces a circle in progress, points on the frame edge
        push_steps(1);
        push_start(16'sd0, 16'sd0, '0, 32'hFFFF_FFFF);
        push_steps(2);
        push_start(16'sd100, 16'sd100, 15'd5, 32'hA5A5_5A5A);
        push_steps(5);
        push_start(16'sd32767, 16'sh8000, 15'd32767, 32'h0000_0000);
        push_steps(2);
        push_start(16'sh8000, 16'sd32767, 15'd3, 32'h5A5A_A5A5);
        push_steps(2);
        push_start(16'sd639, 16'sd479, 15'd1, 32'h1234_5678);
        push_steps(2);

        for (p = 0; p < 6; p++)
        begin
            wait_idle();
            write_frame(REG_FRAME_WIDTH, widths[p]);
            write_frame(REG_FRAME_HEIGHT, heights[p]);
            idle_on = (p != 2) && (p != 5);
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                queue_random_circle(u);
                made += u;
            end
        end

        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
